/* hw/rtl/assert_macros.svh */
// Assertion macros for RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true on a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

/* hw/rtl/cmfd_pkg.sv */
// Shared types, constants and CRC helpers of the cell monitor frame decoder.
package cmfd_pkg;

  localparam int FRAME_BYTES = 19;
  localparam int POS_W       = $clog2(FRAME_BYTES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int NUM_CELLS   = 6;

  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] CRC_START = 8'h00;
  localparam logic [7:0] REG_START = 8'h00;

  // cell mV = raw * 6250 / 16383
  localparam int CELL_MUL = 6250;
  localparam int CELL_DEN = 16383;
  // discharge mA = d * 35 / 10 = (d * 7) >> 1
  localparam int DIS_MUL = 7;
  // charge mA = d * 1480 / 1000 = d * 37 / 25, /25 by reciprocal
  localparam int CHG_RECIP = 5368710;
  localparam int CHG_SHIFT = 27;
  // temperature C = (raw >> 3) / 13, /13 by reciprocal
  localparam int TEMP_PRE_SHIFT = 3;
  localparam int TEMP_RECIP     = 10083;
  localparam int TEMP_SHIFT     = 17;

  localparam int OPERAND_W = 23;
  localparam int PROD_W    = 46;

  typedef enum logic [2:0] {
    QTY_CELL_MV      = 3'd0,
    QTY_DISCHARGE_MA = 3'd1,
    QTY_CHARGE_MA    = 3'd2,
    QTY_TEMP_C       = 3'd3,
    QTY_RAW_TS1      = 3'd4,
    QTY_RAW_TS2      = 3'd5
  } quantity_t;

  typedef enum logic [1:0] {
    CFG_DISCHARGE_OFFSET = 2'd0,
    CFG_CHARGE_OFFSET    = 2'd1,
    CFG_TEMP_OFFSET      = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [2:0]                 device;
    logic                       crc_ok;
    logic [NUM_CELLS-1:0][15:0] cell_raw;
    logic [15:0]                discharge_raw;
    logic [15:0]                ts1_raw;
    logic [15:0]                ts2_raw;
  } frame_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [7:0] crc_update(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // CRC after the request header (addr << 1, start register, byte count), per address
  function automatic logic [63:0] build_header_seeds();
    logic [63:0] seeds;
    logic [7:0]  c;
    seeds = '0;
    for (int a = 0; a < 8; a++) begin
      c = crc_update(CRC_START, 8'(a << 1));
      c = crc_update(c, REG_START);
      c = crc_update(c, 8'(FRAME_BYTES));
      seeds[a*8 +: 8] = c;
    end
    return seeds;
  endfunction

  localparam logic [63:0] HEADER_SEEDS = build_header_seeds();

endpackage

/* hw/rtl/cmfd_front.sv */
// Front end: takes reply bytes, runs the CRC, buffers the frame and posts a decode job.
module cmfd_front
  import cmfd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    in_device_addr,
  input  logic [7:0]    in_rx_byte,
  input  logic          in_first,
  input  queue_status_t q_status,
  output logic          push,
  output frame_job_t    job
);

  logic [7:0]       crc_r, crc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [2:0]       dev_r, dev_nxt;
  logic [7:0]       frame_buf_r [FRAME_BYTES];
  logic             accept;
  logic             shift_in;
  logic             at_crc_byte;

  assign in_stall    = q_status.full;
  assign accept      = in_valid && !in_stall;
  assign at_crc_byte = (pos_r == POS_W'(FRAME_BYTES));
  assign shift_in    = accept && (in_first || (pos_r != '0 && !at_crc_byte));
  assign push        = accept && !in_first && at_crc_byte;

  always_comb begin
    crc_nxt = crc_r;
    pos_nxt = pos_r;
    dev_nxt = dev_r;
    if (accept) begin
      if (in_first) begin
        crc_nxt = crc_update(HEADER_SEEDS[{in_device_addr, 3'b000} +: 8], in_rx_byte);
        pos_nxt = POS_W'(1);
        dev_nxt = in_device_addr;
      end else if (pos_r != '0) begin
        if (at_crc_byte) begin
          pos_nxt = '0;
        end else begin
          crc_nxt = crc_update(crc_r, in_rx_byte);
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
      pos_r <= '0;
      dev_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      pos_r <= pos_nxt;
      dev_r <= dev_nxt;
    end
  end

  // newest byte at index 0; byte k of a full frame sits at FRAME_BYTES-1-k
  always_ff @(posedge clk) begin
    if (shift_in) begin
      frame_buf_r[0] <= in_rx_byte;
      for (int i = 1; i < FRAME_BYTES; i++) begin
        frame_buf_r[i] <= frame_buf_r[i-1];
      end
    end
  end

  always_comb begin
    job.device        = dev_r;
    job.crc_ok        = (in_rx_byte == crc_r);
    job.discharge_raw = {frame_buf_r[FRAME_BYTES-2], frame_buf_r[FRAME_BYTES-3]};
    job.ts1_raw       = {frame_buf_r[FRAME_BYTES-16], frame_buf_r[FRAME_BYTES-17]};
    job.ts2_raw       = {frame_buf_r[FRAME_BYTES-18], frame_buf_r[FRAME_BYTES-19]};
    for (int i = 0; i < NUM_CELLS; i++) begin
      job.cell_raw[i] = {frame_buf_r[FRAME_BYTES-4-2*i], frame_buf_r[FRAME_BYTES-5-2*i]};
    end
  end

endmodule

/* hw/rtl/cmfd_queue.sv */
// Job queue between the byte front end and the result back end.
module cmfd_queue
  import cmfd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  frame_job_t    push_job,
  input  logic          pop,
  output frame_job_t    head_job,
  output queue_status_t status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_job_t       entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_job     = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* hw/rtl/cmfd_back.sv */
// Back end: walks a job, one result per unstalled cycle, in a 3-stage conversion pipe.
module cmfd_back
  import cmfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  frame_job_t         job,
  input  queue_status_t      q_status,
  output logic               pop,
  input  logic [15:0]        discharge_offset,
  input  logic [15:0]        charge_offset,
  input  logic [9:0]         temperature_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_quantity,
  output logic [4:0]         out_channel,
  output logic signed [18:0] out_value,
  output logic               out_crc_ok,
  output logic               out_last
);

  localparam int IDX_W = $clog2(NUM_CELLS + 4);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             en;
  logic             issue;
  logic             is_last;
  logic [IDX_W-1:0] n_items;
  logic [2:0]       x;
  logic [IDX_W-1:0] extra;

  logic [16:0]          dis_diff, chg_diff;
  logic [15:0]          chg_d;
  logic [21:0]          chg_x37;
  quantity_t            a_qty;
  logic [4:0]           a_ch;
  logic [OPERAND_W-1:0] a_operand;

  // stage 1: operand selected
  logic                 s1_valid_r;
  quantity_t            s1_qty_r;
  logic [4:0]           s1_ch_r;
  logic                 s1_ok_r;
  logic                 s1_last_r;
  logic [OPERAND_W-1:0] s1_operand_r;
  // stage 2: product
  logic                 s2_valid_r;
  quantity_t            s2_qty_r;
  logic [4:0]           s2_ch_r;
  logic                 s2_ok_r;
  logic                 s2_last_r;
  logic [PROD_W-1:0]    s2_product_r;
  logic [OPERAND_W-1:0] mul_const;
  // stage 3: output register
  logic                 out_valid_r;
  logic [2:0]           out_quantity_r;
  logic [4:0]           out_channel_r;
  logic signed [18:0]   out_value_r;
  logic                 out_crc_ok_r;
  logic                 out_last_r;

  logic [14:0]        cell_q0;
  logic [15:0]        cell_r1;
  logic [1:0]         cell_q1;
  logic [14:0]        cell_r2;
  logic [15:0]        cell_q;
  logic signed [18:0] c_value;

  assign en      = !out_valid_r || !out_stall;
  assign issue   = en && !q_status.empty;
  assign x       = job.device - 3'd1;
  assign n_items = !job.crc_ok ? IDX_W'(NUM_CELLS)
                 : (x == 3'd0) ? IDX_W'(NUM_CELLS + 3) : IDX_W'(NUM_CELLS + 2);
  assign is_last = (idx_r == n_items - 1'b1);
  assign pop     = issue && is_last;
  assign idx_nxt = !issue ? idx_r : (is_last ? '0 : idx_r + 1'b1);
  assign extra   = idx_r - IDX_W'(NUM_CELLS);

  // stage A: pick the result of this slot and its multiplier operand
  always_comb begin
    dis_diff  = {1'b0, job.discharge_raw} - {1'b0, discharge_offset};
    chg_diff  = {1'b0, job.ts1_raw} - {1'b0, charge_offset};
    chg_d     = chg_diff[16] ? '0 : chg_diff[15:0];
    chg_x37   = {1'b0, chg_d, 5'b0} + {4'b0, chg_d, 2'b0} + {6'b0, chg_d};
    a_qty     = QTY_CELL_MV;
    a_ch      = '0;
    a_operand = '0;
    if (idx_r < IDX_W'(NUM_CELLS)) begin
      a_qty     = QTY_CELL_MV;
      a_ch      = 5'({x, 2'b00}) + 5'({x, 1'b0}) + 5'(idx_r) + 5'd1;
      a_operand = job.crc_ok ? OPERAND_W'(job.cell_raw[idx_r[2:0]]) : '0;
    end else if (x == 3'd0) begin
      case (extra)
        IDX_W'(0): begin
          a_qty     = QTY_DISCHARGE_MA;
          a_operand = dis_diff[16] ? '0 : OPERAND_W'(dis_diff[15:0]);
        end
        IDX_W'(1): begin
          a_qty     = QTY_CHARGE_MA;
          a_operand = OPERAND_W'(chg_x37);
        end
        default: begin
          a_qty     = QTY_TEMP_C;
          a_ch      = 5'd1;
          a_operand = OPERAND_W'(job.ts2_raw[15:TEMP_PRE_SHIFT]);
        end
      endcase
    end else begin
      case (extra)
        IDX_W'(0): begin
          a_qty     = QTY_RAW_TS1;
          a_ch      = 5'({x, 1'b0});
          a_operand = OPERAND_W'(job.ts1_raw);
        end
        default: begin
          a_qty     = QTY_RAW_TS2;
          a_ch      = 5'({x, 1'b1});
          a_operand = OPERAND_W'(job.ts2_raw);
        end
      endcase
    end
  end

  always_comb begin
    case (s1_qty_r)
      QTY_CELL_MV:      mul_const = OPERAND_W'(CELL_MUL);
      QTY_DISCHARGE_MA: mul_const = OPERAND_W'(DIS_MUL);
      QTY_CHARGE_MA:    mul_const = OPERAND_W'(CHG_RECIP);
      QTY_TEMP_C:       mul_const = OPERAND_W'(TEMP_RECIP);
      default:          mul_const = OPERAND_W'(1);
    endcase
  end

  // stage C: shifts and the /16383 fold for cells
  always_comb begin
    cell_q0 = s2_product_r[28:14];
    cell_r1 = 16'(s2_product_r[13:0]) + 16'(cell_q0);
    cell_q1 = cell_r1[15:14];
    cell_r2 = 15'(cell_r1[13:0]) + 15'(cell_q1);
    cell_q  = 16'(cell_q0) + 16'(cell_q1) + 16'(cell_r2 >= 15'(CELL_DEN));
    case (s2_qty_r)
      QTY_CELL_MV:      c_value = 19'(cell_q);
      QTY_DISCHARGE_MA: c_value = 19'(s2_product_r[18:1]);
      QTY_CHARGE_MA:    c_value = 19'(s2_product_r[CHG_SHIFT +: 19]);
      QTY_TEMP_C:       c_value = $signed({9'b0, s2_product_r[TEMP_SHIFT +: 10]})
                                - $signed({9'b0, temperature_offset});
      default:          c_value = 19'(s2_product_r[15:0]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (en) begin
        s1_valid_r  <= issue;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_qty_r       <= a_qty;
      s1_ch_r        <= a_ch;
      s1_ok_r        <= job.crc_ok;
      s1_last_r      <= is_last;
      s1_operand_r   <= a_operand;
      s2_qty_r       <= s1_qty_r;
      s2_ch_r        <= s1_ch_r;
      s2_ok_r        <= s1_ok_r;
      s2_last_r      <= s1_last_r;
      s2_product_r   <= PROD_W'(s1_operand_r * mul_const);
      out_quantity_r <= s2_qty_r;
      out_channel_r  <= s2_ch_r;
      out_value_r    <= c_value;
      out_crc_ok_r   <= s2_ok_r;
      out_last_r     <= s2_last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_quantity = out_quantity_r;
  assign out_channel  = out_channel_r;
  assign out_value    = out_value_r;
  assign out_crc_ok   = out_crc_ok_r;
  assign out_last     = out_last_r;

endmodule

/* hw/rtl/cell_monitor_frame_decoder.sv */
// Top level of the cell monitor frame decoder: config registers, front, queue, back.
//
//  port group   role      transaction
//  in_*         input     one reply byte, taken when in_valid && !in_stall
//  out_*        result    one converted value, taken when out_valid && !out_stall
//  cfg_*        config    register write on cfg_wr_en, no wait
//
// One byte is taken per cycle unless stalled; a frame's CRC byte posts a job to a two-entry queue.
// The back end drains a job, one result per unstalled cycle: 6 on a CRC error, 8 or 9 otherwise.
// A slot issued from the queue head passes the s1, s2 and output registers to reach out_*.
// in_stall rises only while the queue holds two frames not yet drained.
// rst_n is synchronous, active low; the frame buffer and pipe payload are not reset.
module cell_monitor_frame_decoder
  import cmfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_device_addr,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_first,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_quantity,
  output logic [4:0]         out_channel,
  output logic signed [18:0] out_value,
  output logic               out_crc_ok,
  output logic               out_last,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  `include "assert_macros.svh"

  logic [15:0]   discharge_offset_r;
  logic [15:0]   charge_offset_r;
  logic [9:0]    temperature_offset_r;
  logic          push;
  logic          pop;
  frame_job_t    push_job;
  frame_job_t    head_job;
  queue_status_t q_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discharge_offset_r   <= '0;
      charge_offset_r      <= '0;
      temperature_offset_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DISCHARGE_OFFSET: discharge_offset_r   <= cfg_data;
        CFG_CHARGE_OFFSET:    charge_offset_r      <= cfg_data;
        CFG_TEMP_OFFSET:      temperature_offset_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  cmfd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_device_addr (in_device_addr),
    .in_rx_byte     (in_rx_byte),
    .in_first       (in_first),
    .q_status       (q_status),
    .push           (push),
    .job            (push_job)
  );

  cmfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  cmfd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job                (head_job),
    .q_status           (q_status),
    .pop                (pop),
    .discharge_offset   (discharge_offset_r),
    .charge_offset      (charge_offset_r),
    .temperature_offset (temperature_offset_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_quantity       (out_quantity),
    .out_channel        (out_channel),
    .out_value          (out_value),
    .out_crc_ok         (out_crc_ok),
    .out_last           (out_last)
  );

  `ASSERT_NEVER(a_push_into_full, push && q_status.full, "frame job pushed into a full queue")
  `ASSERT_NEVER(a_pop_from_empty, pop && q_status.empty, "job popped from an empty queue")
  `ASSERT_CLK(a_bad_crc_zero_cells, out_valid && !out_crc_ok |-> out_quantity == QTY_CELL_MV && out_value == '0, "CRC error result is not a zero cell voltage")
  `ASSERT_CLK(a_good_frame_ends_past_cells, out_valid && out_last && out_crc_ok |-> out_quantity != QTY_CELL_MV, "good frame ended on a cell voltage")

endmodule

/* test/cell_monitor_frame_decoder_tb.sv */
// Self-checking testbench of the cell monitor frame decoder: frames in, checked readings out.
module cell_monitor_frame_decoder_tb;
  import cmfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_BYTES  = 44;
  localparam int DRAIN_CYCLES = 16;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_device_addr = '0;
  logic [7:0]         in_rx_byte = '0;
  logic               in_first = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_quantity;
  logic [4:0]         out_channel;
  logic signed [18:0] out_value;
  logic               out_crc_ok;
  logic               out_last;
  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_go = 1'b0;
  int          hold_left = 0;
  int          taken_bytes = 0;
  int unsigned cycle_count = 0;
  logic [7:0]  tx_regs[FRAME_BYTES];

  typedef struct packed {
    quantity_t   qty;
    logic [4:0]  chan;
    logic [18:0] val;
    logic        ok;
    logic        last;
  } reading_t;

  // bitwise MSB-first CRC-8, one data bit per iteration
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    logic       fb;
    acc = crc;
    for (int b = 7; b >= 0; b--) begin
      fb  = acc[7] ^ data[b];
      acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

  // CRC state after the read request header for this address
  function automatic logic [7:0] header_crc(input logic [2:0] addr);
    logic [7:0] c;
    c = crc8_step(CRC_START, {4'b0000, addr, 1'b0});
    c = crc8_step(c, REG_START);
    return crc8_step(c, 8'(FRAME_BYTES));
  endfunction

  class reading_board;
    reading_t    pending_readings[$];
    int unsigned mismatches = 0;
    logic [15:0] dis_off = '0;
    logic [15:0] chg_off = '0;
    logic [9:0]  temp_off = '0;
    logic [7:0]  crc_acc = '0;
    int unsigned fill = 0;
    logic [7:0]  frame_buf[FRAME_BYTES];
    logic [2:0]  frame_dev = '0;

    function void set_offsets(logic [15:0] dis, logic [15:0] chg, logic [9:0] tmp);
      dis_off  = dis;
      chg_off  = chg;
      temp_off = tmp;
    endfunction

    function longint word(int unsigned idx);
      return longint'({frame_buf[idx], frame_buf[idx+1]});
    endfunction

    function void add(quantity_t q, int unsigned ch, longint v, logic ok, logic last);
      reading_t r;
      r.qty  = q;
      r.chan = 5'(ch);
      r.val  = 19'(v);
      r.ok   = ok;
      r.last = last;
      pending_readings.push_back(r);
    endfunction

    function void post_readings(logic [7:0] crc_byte);
      int unsigned x;
      int unsigned n;
      logic        ok;
      longint      raw;
      longint      cur;
      ok = (crc_byte == crc_acc);
      x  = 3'(frame_dev - 3'd1);
      n  = !ok ? 6 : (x == 0 ? 9 : 8);
      for (int i = 0; i < NUM_CELLS; i++)
        add(QTY_CELL_MV, x * 6 + 1 + i, ok ? word(3 + 2 * i) * 6250 / 16383 : 0, ok,
            n == i + 1);
      if (!ok)
        return;
      if (x == 0) begin
        raw = word(1);
        cur = (raw >= dis_off) ? (raw - dis_off) * 35 / 10 : 0;
        add(QTY_DISCHARGE_MA, 0, cur, ok, 1'b0);
        raw = word(15);
        cur = (raw >= chg_off) ? (raw - chg_off) * 1480 / 1000 : 0;
        add(QTY_CHARGE_MA, 0, cur, ok, 1'b0);
        add(QTY_TEMP_C, 1, word(17) / 104 - longint'(temp_off), ok, 1'b1);
      end else begin
        add(QTY_RAW_TS1, 2 * x, word(15), ok, 1'b0);
        add(QTY_RAW_TS2, 2 * x + 1, word(17), ok, 1'b1);
      end
    endfunction

    // returns 1 when the byte is dropped (no frame open)
    function bit take_byte(logic [2:0] addr, logic [7:0] rx, logic first);
      if (first) begin
        frame_dev    = addr;
        frame_buf[0] = rx;
        crc_acc      = crc8_step(header_crc(addr), rx);
        fill         = 1;
        return 1'b0;
      end
      if (fill == 0)
        return 1'b1;
      if (fill < FRAME_BYTES) begin
        frame_buf[fill] = rx;
        crc_acc         = crc8_step(crc_acc, rx);
        fill++;
        return 1'b0;
      end
      fill = 0;
      post_readings(rx);
      return 1'b0;
    endfunction

    function void check_reading(logic [2:0] q, logic [4:0] ch, logic [18:0] v, logic ok,
                                logic last);
      reading_t e;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reading: qty %0d ch %0d value %0d crc_ok %0b last %0b",
                   q, ch, $signed(v), ok, last);
        return;
      end
      e = pending_readings.pop_front();
      if ({e.qty, e.chan, e.val, e.ok, e.last} !== {q, ch, v, ok, last}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reading mismatch: exp qty %0d ch %0d value %0d crc_ok %0b last %0b, %s",
                   e.qty, e.chan, $signed(e.val), e.ok, e.last,
                   $sformatf("got qty %0d ch %0d value %0d crc_ok %0b last %0b",
                             q, ch, $signed(v), ok, last));
      end
    endfunction
  endclass

  reading_board board;

  cell_monitor_frame_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_device_addr (in_device_addr),
    .in_rx_byte     (in_rx_byte),
    .in_first       (in_first),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_quantity   (out_quantity),
    .out_channel    (out_channel),
    .out_value      (out_value),
    .out_crc_ok     (out_crc_ok),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: check each transaction, then pick next cycle's stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_reading(out_quantity, out_channel, out_value, out_crc_ok, out_last);
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go   = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_byte(input logic [2:0] addr, input logic [7:0] rx, input logic first);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid       <= 1'b0;
      in_device_addr <= 3'($urandom);
      in_rx_byte     <= 8'($urandom);
      in_first       <= 1'($urandom);
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_device_addr <= addr;
    in_rx_byte     <= rx;
    in_first       <= first;
    do @(posedge clk); while (in_stall);
    if (!board.take_byte(addr, rx, first))
      taken_bytes++;
  endtask

  task automatic send_frame(input logic [2:0] addr, input bit good_crc);
    logic [7:0] crc;
    crc = header_crc(addr);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      send_byte(i == 0 ? addr : 3'($urandom), tx_regs[i], i == 0);
      crc = crc8_step(crc, tx_regs[i]);
    end
    send_byte(3'($urandom), good_crc ? crc : crc ^ 8'($urandom_range(1, 255)), 1'b0);
  endtask

  function automatic logic [2:0] pick_addr();
    int r;
    r = $urandom_range(99);
    if (r < 40)
      return 3'd1;
    if (r < 80)
      return 3'($urandom_range(2, 4));
    r = $urandom_range(3);
    return (r == 0) ? 3'd0 : 3'(4 + r);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 20)
      return 8'h00;
    if (r < 40)
      return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic void fill_regs();
    for (int i = 0; i < FRAME_BYTES; i++)
      tx_regs[i] = pick_byte();
  endfunction

  // every episode leaves the decoder with no frame open
  task automatic random_episode();
    int         kind;
    int         n;
    logic [2:0] addr;
    kind = $urandom_range(99);
    addr = pick_addr();
    if (kind < 10) begin
      n = $urandom_range(1, 3);
      repeat (n) send_byte(3'($urandom), 8'($urandom), 1'b0);
    end else if (kind < 22) begin
      // abandoned frame, possibly right before its CRC byte, then a restart
      n = $urandom_range(0, FRAME_BYTES - 1);
      send_byte(addr, pick_byte(), 1'b1);
      repeat (n) send_byte(3'($urandom), pick_byte(), 1'b0);
      fill_regs();
      send_frame(pick_addr(), $urandom_range(99) < 75);
    end else begin
      fill_regs();
      send_frame(addr, $urandom_range(99) < 75);
    end
  endtask

  task automatic write_offsets(input logic [15:0] dis, input logic [15:0] chg,
                               input logic [9:0] tmp);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_DISCHARGE_OFFSET;
    cfg_data  <= dis;
    @(posedge clk);
    cfg_index <= CFG_CHARGE_OFFSET;
    cfg_data  <= chg;
    @(posedge clk);
    cfg_index <= CFG_TEMP_OFFSET;
    cfg_data  <= 16'(tmp);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_offsets(dis, chg, tmp);
  endtask

  task automatic drain_readings();
    in_valid <= 1'b0;
    while (board.pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stray byte, restart over an open frame, extreme values, stray after the end
    write_offsets(16'hFFFF, 16'h0000, 10'd630);
    tx_regs = '{8'h5A, 8'hFF, 8'hFF,
                8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h00,
                8'h3F, 8'hFF, 8'h7F, 8'hFF, 8'h00, 8'h01,
                8'hFF, 8'hFF, 8'h00, 8'h00};
    send_byte(3'd6, 8'hA5, 1'b0);
    send_byte(3'd7, 8'h3C, 1'b1);
    send_frame(3'd1, 1'b1);
    send_byte(3'd0, 8'hC3, 1'b0);
    drain_readings();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          write_offsets(16'h0000, 16'h0000, 10'd0);
          hold_go = 1'b1;  // long receiver hold so the input backs up
        end
        1: begin
          send_idle_pct = 50;
          stall_pct     = 0;
          write_offsets(16'hFFFF, 16'hFFFF, 10'd630);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 50;
          write_offsets(16'($urandom), 16'($urandom), 10'($urandom_range(0, 630)));
        end
        default: begin
          send_idle_pct = 36;
          stall_pct     = 36;
          write_offsets(16'($urandom), 16'($urandom), 10'd1023);
        end
      endcase
      taken_bytes = 0;
      while (taken_bytes < PHASE_BYTES) random_episode();
      drain_readings();
    end

    if (board.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
